[design/nmmq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nmmq_pkg
// Shared constants and types for the named mailbox message queue block:
// default sizes, command and status codes, and the box table control bundle.
// ----------------------------------------------------------------------------
package nmmq_pkg;

  // Default sizes handed to the top level parameters.
  localparam int NUM_BOXES_DEF     = 16;
  localparam int SLOTS_PER_BOX_DEF = 16;
  localparam int MSG_BYTES_DEF     = 8;
  localparam int NAME_BYTES_DEF    = 8;

  // User count width and its saturation value.
  localparam int         USER_W   = 8;
  localparam logic [7:0] USER_MAX = 8'hFF;

  // Command codes.
  localparam logic [1:0] CMD_OPEN  = 2'd0;
  localparam logic [1:0] CMD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_SEND  = 2'd2;
  localparam logic [1:0] CMD_RECV  = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_NOFREE  = 3'd3;
  localparam logic [2:0] ST_NOTOPEN = 3'd4;
  localparam logic [2:0] ST_USERLIM = 3'd5;

  // Control bundle from the sequencer to the box table.
  typedef struct packed {
    logic rd_en;    // read the entry at the read address
    logic wr_en;    // write the entry at the write address
    logic use_set;  // mark the write address in use
    logic use_clr;  // free the write address
  } tbl_ctl_t;

endpackage
`default_nettype wire

[design/nmmq_box_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nmmq_box_table
// Per-box descriptor memory (name, user count, read and write counters) with
// one registered read port and one write port. In-use flags live in flops
// and gate the read data, so a free box always reads as all zero.
// ----------------------------------------------------------------------------
module nmmq_box_table #(
  parameter int NUM_BOXES = 16,
  parameter int BOX_W     = 4,
  parameter int NAME_W    = 64,
  parameter int CTR_W     = 5
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire nmmq_pkg::tbl_ctl_t       ctl,
  input  wire logic [BOX_W-1:0]         raddr,
  input  wire logic [BOX_W-1:0]         waddr,
  input  wire logic [NAME_W-1:0]        d_name,
  input  wire logic [nmmq_pkg::USER_W-1:0] d_users,
  input  wire logic [CTR_W-1:0]         d_rctr,
  input  wire logic [CTR_W-1:0]         d_wctr,
  output logic                          q_in_use,
  output logic [NAME_W-1:0]             q_name,
  output logic [nmmq_pkg::USER_W-1:0]   q_users,
  output logic [CTR_W-1:0]              q_rctr,
  output logic [CTR_W-1:0]              q_wctr
);
  import nmmq_pkg::*;

  localparam int ENT_W = NAME_W + USER_W + 2 * CTR_W;

  logic [ENT_W-1:0]     mem [NUM_BOXES];
  logic [ENT_W-1:0]     rdata_r;
  logic                 ruse_r;
  logic [NUM_BOXES-1:0] in_use_r;

  // Descriptor memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= {d_name, d_users, d_rctr, d_wctr};
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  // In-use flags, cleared at reset; sampled alongside the read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      ruse_r   <= 1'b0;
    end else begin
      if (ctl.use_set) begin
        in_use_r[waddr] <= 1'b1;
      end else if (ctl.use_clr) begin
        in_use_r[waddr] <= 1'b0;
      end
      if (ctl.rd_en) begin
        ruse_r <= in_use_r[raddr];
      end
    end
  end

  // A free box reads as all zero.
  always_comb begin
    q_in_use = ruse_r;
    if (ruse_r) begin
      {q_name, q_users, q_rctr, q_wctr} = rdata_r;
    end else begin
      {q_name, q_users, q_rctr, q_wctr} = '0;
    end
  end

endmodule
`default_nettype wire

[design/nmmq_slot_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nmmq_slot_store
// Message slot memory for all boxes: single port, byte-enable write,
// registered read.
// ----------------------------------------------------------------------------
module nmmq_slot_store #(
  parameter int DEPTH     = 256,
  parameter int ADDR_W    = 8,
  parameter int MSG_BYTES = 8
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic                   re,
  input  wire logic [ADDR_W-1:0]      addr,
  input  wire logic [MSG_BYTES-1:0]   be,
  input  wire logic [MSG_BYTES*8-1:0] wdata,
  output logic      [MSG_BYTES*8-1:0] rdata
);

  logic [MSG_BYTES*8-1:0] mem [DEPTH];

  // Byte lanes are written independently; read data is registered.
  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < MSG_BYTES; i++) begin
        if (be[i]) begin
          mem[addr][i*8 +: 8] <= wdata[i*8 +: 8];
        end
      end
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

[design/named_mailbox_message_queues_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// named_mailbox_message_queues_unit
// Table of named mailboxes, each a ring of message slots, driven by open,
// close, send and receive commands.
// ----------------------------------------------------------------------------
// After reset the block sweeps all NUM_BOXES*SLOTS_PER_BOX slots of the slot
// memory to zero, one slot a cycle; in_ready stays low meanwhile. Then it
// handles one command at a time. Close, send and receive read the box
// descriptor, update it and the slot memory in the execute state, and pass
// the result through the output state (an out of range box number goes
// straight to the output state). Open walks the descriptor table one entry
// a cycle through its single read port, looking for a matching name while
// remembering the first free box. A finished result waits in an output
// register, so the next command can be accepted while the previous result
// is still pending. Nothing ever blocks inside: full, empty, no free box,
// box not open and user limit are reported in the status field.
// ----------------------------------------------------------------------------
module named_mailbox_message_queues_unit #(
  parameter int NUM_BOXES     = nmmq_pkg::NUM_BOXES_DEF,
  parameter int SLOTS_PER_BOX = nmmq_pkg::SLOTS_PER_BOX_DEF,
  parameter int MSG_BYTES     = nmmq_pkg::MSG_BYTES_DEF,
  parameter int NAME_BYTES    = nmmq_pkg::NAME_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [3:0]  in_box_id,
  input  wire logic [63:0] in_name_key,
  input  wire logic [63:0] in_tx_data,
  input  wire logic [3:0]  in_byte_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [3:0]       out_box_out,
  output logic [63:0]      out_rx_data,
  output logic             out_box_full,
  output logic             out_box_empty
);
  import nmmq_pkg::*;

  localparam int NAME_W  = NAME_BYTES * 8;
  localparam int MSG_W   = MSG_BYTES * 8;
  localparam int BOX_W   = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
  localparam int CTR_MOD = 2 * SLOTS_PER_BOX;
  localparam int CTR_W   = $clog2(CTR_MOD);
  localparam int SLOT_W  = (SLOTS_PER_BOX > 1) ? $clog2(SLOTS_PER_BOX) : 1;
  localparam int DEPTH   = NUM_BOXES * SLOTS_PER_BOX;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [CTR_W:0]    MOD_F    = CTR_MOD[CTR_W:0];
  localparam logic [CTR_W:0]    SLOTS_F  = SLOTS_PER_BOX[CTR_W:0];
  localparam logic [CTR_W-1:0]  SLOTS_C  = SLOTS_PER_BOX[CTR_W-1:0];
  localparam logic [CTR_W-1:0]  CTR_LAST = CTR_W'(CTR_MOD - 1);
  localparam logic [ADDR_W-1:0] SLOTS_A  = ADDR_W'(SLOTS_PER_BOX);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [BOX_W-1:0]  BOX_LAST = BOX_W'(NUM_BOXES - 1);
  localparam logic [3:0]        MSG_BYTES_C = 4'(MSG_BYTES);

  // Sequencer states.
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // Messages held, from the two ring counters.
  function automatic logic [CTR_W:0] fill_of(input logic [CTR_W-1:0] wc,
                                             input logic [CTR_W-1:0] rc);
    if (wc >= rc) begin
      fill_of = {1'b0, wc} - {1'b0, rc};
    end else begin
      fill_of = {1'b0, wc} + MOD_F - {1'b0, rc};
    end
  endfunction

  function automatic logic [CTR_W-1:0] ctr_inc(input logic [CTR_W-1:0] c);
    ctr_inc = (c == CTR_LAST) ? '0 : c + 1'b1;
  endfunction

  // Slot memory address of a counter within a box.
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [BOX_W-1:0] b,
                                                  input logic [CTR_W-1:0] c);
    logic [CTR_W-1:0] idx;
    idx = (c >= SLOTS_C) ? c - SLOTS_C : c;
    slot_addr = ADDR_W'(b) * SLOTS_A + ADDR_W'(idx[SLOT_W-1:0]);
  endfunction

  function automatic logic [MSG_BYTES-1:0] byte_en(input logic [3:0] n);
    for (int i = 0; i < MSG_BYTES; i++) begin
      byte_en[i] = (4'(i) < n);
    end
  endfunction

  function automatic logic [MSG_W-1:0] byte_mask(input logic [3:0] n);
    for (int i = 0; i < MSG_BYTES; i++) begin
      byte_mask[i*8 +: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
    end
  endfunction

  // Control registers.
  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Command and scan registers.
  logic [1:0]        cmd_r, cmd_nxt;
  logic [3:0]        box_r, box_nxt;
  logic [NAME_W-1:0] key_r, key_nxt;
  logic [MSG_W-1:0]  tx_r, tx_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [BOX_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic              free_found_r, free_found_nxt;
  logic [BOX_W-1:0]  free_idx_r, free_idx_nxt;

  // Pending result and output registers.
  logic [2:0]  res_status_r, res_status_nxt;
  logic [3:0]  res_box_r, res_box_nxt;
  logic        res_full_r, res_full_nxt;
  logic        res_empty_r, res_empty_nxt;
  logic        res_rx_ok_r, res_rx_ok_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [3:0]  out_box_r, out_box_nxt;
  logic [63:0] out_rx_r, out_rx_nxt;
  logic        out_full_r, out_full_nxt;
  logic        out_empty_r, out_empty_nxt;

  // Box table interface.
  tbl_ctl_t          tbl_ctl;
  logic [BOX_W-1:0]  tbl_raddr, tbl_waddr;
  logic [NAME_W-1:0] tbl_d_name, tbl_q_name;
  logic [USER_W-1:0] tbl_d_users, tbl_q_users;
  logic [CTR_W-1:0]  tbl_d_rctr, tbl_d_wctr, tbl_q_rctr, tbl_q_wctr;
  logic              tbl_q_in_use;

  // Slot store interface.
  logic              slot_we, slot_re;
  logic [ADDR_W-1:0] slot_addr_c;
  logic [MSG_BYTES-1:0] slot_be;
  logic [MSG_W-1:0]  slot_wdata, slot_q;

  // Working values.
  logic [CTR_W:0]    fill_cur;
  logic [CTR_W-1:0]  rctr_new, wctr_new;
  logic [USER_W-1:0] users_dec;
  logic              scan_hit, scan_last, claim;
  logic [BOX_W-1:0]  claim_idx, exec_box;
  logic [3:0]        cnt_clamp;

  nmmq_box_table #(
    .NUM_BOXES (NUM_BOXES),
    .BOX_W     (BOX_W),
    .NAME_W    (NAME_W),
    .CTR_W     (CTR_W)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (tbl_ctl),
    .raddr    (tbl_raddr),
    .waddr    (tbl_waddr),
    .d_name   (tbl_d_name),
    .d_users  (tbl_d_users),
    .d_rctr   (tbl_d_rctr),
    .d_wctr   (tbl_d_wctr),
    .q_in_use (tbl_q_in_use),
    .q_name   (tbl_q_name),
    .q_users  (tbl_q_users),
    .q_rctr   (tbl_q_rctr),
    .q_wctr   (tbl_q_wctr)
  );

  nmmq_slot_store #(
    .DEPTH     (DEPTH),
    .ADDR_W    (ADDR_W),
    .MSG_BYTES (MSG_BYTES)
  ) u_slots (
    .clk   (clk),
    .we    (slot_we),
    .re    (slot_re),
    .addr  (slot_addr_c),
    .be    (slot_be),
    .wdata (slot_wdata),
    .rdata (slot_q)
  );

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_box_out   = out_box_r;
  assign out_rx_data   = out_rx_r;
  assign out_box_full  = out_full_r;
  assign out_box_empty = out_empty_r;

  // Values derived from the descriptor that was just read.
  assign cnt_clamp = (in_byte_count > MSG_BYTES_C) ? MSG_BYTES_C : in_byte_count;
  assign fill_cur  = fill_of(tbl_q_wctr, tbl_q_rctr);
  assign rctr_new  = ctr_inc(tbl_q_rctr);
  assign wctr_new  = ctr_inc(tbl_q_wctr);
  assign users_dec = (tbl_q_users != '0) ? tbl_q_users - 1'b1 : '0;
  assign scan_hit  = tbl_q_in_use && (tbl_q_name == key_r);
  assign scan_last = (scan_idx_r == BOX_LAST);
  assign claim     = free_found_r || !tbl_q_in_use;
  assign claim_idx = free_found_r ? free_idx_r : scan_idx_r;
  assign exec_box  = BOX_W'(box_r);

  // Sequencer: next state, memory accesses and result formation.
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    cmd_nxt        = cmd_r;
    box_nxt        = box_r;
    key_nxt        = key_r;
    tx_nxt         = tx_r;
    cnt_nxt        = cnt_r;
    scan_idx_nxt   = scan_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    res_status_nxt = res_status_r;
    res_box_nxt    = res_box_r;
    res_full_nxt   = res_full_r;
    res_empty_nxt  = res_empty_r;
    res_rx_ok_nxt  = res_rx_ok_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_box_nxt    = out_box_r;
    out_rx_nxt     = out_rx_r;
    out_full_nxt   = out_full_r;
    out_empty_nxt  = out_empty_r;

    tbl_ctl     = '0;
    tbl_raddr   = '0;
    tbl_waddr   = '0;
    tbl_d_name  = tbl_q_name;
    tbl_d_users = tbl_q_users;
    tbl_d_rctr  = tbl_q_rctr;
    tbl_d_wctr  = tbl_q_wctr;

    slot_we     = 1'b0;
    slot_re     = 1'b0;
    slot_addr_c = '0;
    slot_be     = '0;
    slot_wdata  = tx_r;

    case (state_r)
      // Zero the slot memory after reset, one slot a cycle.
      S_CLR: begin
        slot_we     = 1'b1;
        slot_addr_c = clr_addr_r;
        slot_be     = '1;
        slot_wdata  = '0;
        if (clr_addr_r == ADDR_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end

      // Take a command beat and start the descriptor read.
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = in_cmd;
          box_nxt        = in_box_id;
          key_nxt        = in_name_key[NAME_W-1:0];
          tx_nxt         = in_tx_data[MSG_W-1:0];
          cnt_nxt        = cnt_clamp;
          res_rx_ok_nxt  = 1'b0;
          scan_idx_nxt   = '0;
          free_found_nxt = 1'b0;
          if (in_cmd == CMD_OPEN) begin
            tbl_ctl.rd_en = 1'b1;
            tbl_raddr     = '0;
            state_nxt     = S_SCAN;
          end else if (32'(in_box_id) >= NUM_BOXES) begin
            res_status_nxt = ST_NOTOPEN;
            res_box_nxt    = in_box_id;
            res_full_nxt   = 1'b0;
            res_empty_nxt  = 1'b0;
            state_nxt      = S_OUT;
          end else begin
            tbl_ctl.rd_en = 1'b1;
            tbl_raddr     = BOX_W'(in_box_id);
            state_nxt     = S_EXEC;
          end
        end
      end

      // Open: one descriptor per cycle, match by name, else claim first free.
      S_SCAN: begin
        if (scan_hit) begin
          res_box_nxt   = 4'(scan_idx_r);
          res_full_nxt  = (fill_cur >= SLOTS_F);
          res_empty_nxt = (fill_cur == '0);
          if (tbl_q_users == USER_MAX) begin
            res_status_nxt = ST_USERLIM;
          end else begin
            res_status_nxt = ST_OK;
            tbl_ctl.wr_en  = 1'b1;
            tbl_waddr      = scan_idx_r;
            tbl_d_users    = tbl_q_users + 1'b1;
          end
          state_nxt = S_OUT;
        end else if (scan_last) begin
          if (claim) begin
            tbl_ctl.wr_en   = 1'b1;
            tbl_ctl.use_set = 1'b1;
            tbl_waddr       = claim_idx;
            tbl_d_name      = key_r;
            tbl_d_users     = USER_W'(1);
            tbl_d_rctr      = '0;
            tbl_d_wctr      = '0;
            res_status_nxt  = ST_OK;
            res_box_nxt     = 4'(claim_idx);
            res_full_nxt    = 1'b0;
            res_empty_nxt   = 1'b1;
          end else begin
            res_status_nxt = ST_NOFREE;
            res_box_nxt    = '0;
            res_full_nxt   = 1'b0;
            res_empty_nxt  = 1'b0;
          end
          state_nxt = S_OUT;
        end else begin
          if (!free_found_r && !tbl_q_in_use) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = scan_idx_r;
          end
          tbl_ctl.rd_en = 1'b1;
          tbl_raddr     = scan_idx_r + 1'b1;
          scan_idx_nxt  = scan_idx_r + 1'b1;
        end
      end

      // Close, send or receive on an addressed box.
      S_EXEC: begin
        res_box_nxt    = box_r;
        res_status_nxt = ST_OK;
        res_full_nxt   = (fill_cur >= SLOTS_F);
        res_empty_nxt  = (fill_cur == '0);
        tbl_waddr      = exec_box;
        if (!tbl_q_in_use) begin
          res_status_nxt = ST_NOTOPEN;
        end else begin
          case (cmd_r)
            CMD_CLOSE: begin
              if (users_dec == '0) begin
                tbl_ctl.use_clr = 1'b1;
                res_full_nxt    = 1'b0;
                res_empty_nxt   = 1'b1;
              end else begin
                tbl_ctl.wr_en = 1'b1;
                tbl_d_users   = users_dec;
              end
            end
            CMD_SEND: begin
              if (fill_cur >= SLOTS_F) begin
                res_status_nxt = ST_FULL;
              end else begin
                slot_we       = 1'b1;
                slot_addr_c   = slot_addr(exec_box, tbl_q_wctr);
                slot_be       = byte_en(cnt_r);
                tbl_ctl.wr_en = 1'b1;
                tbl_d_wctr    = wctr_new;
                res_full_nxt  = (fill_of(wctr_new, tbl_q_rctr) >= SLOTS_F);
                res_empty_nxt = 1'b0;
              end
            end
            CMD_RECV: begin
              if (fill_cur == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                slot_re       = 1'b1;
                slot_addr_c   = slot_addr(exec_box, tbl_q_rctr);
                res_rx_ok_nxt = 1'b1;
                tbl_ctl.wr_en = 1'b1;
                tbl_d_rctr    = rctr_new;
                res_full_nxt  = 1'b0;
                res_empty_nxt = (fill_of(tbl_q_wctr, rctr_new) == '0);
              end
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end
        state_nxt = S_OUT;
      end

      // Hand the result to the output register once it is free.
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_box_nxt    = res_box_r;
          out_full_nxt   = res_full_r;
          out_empty_nxt  = res_empty_r;
          out_rx_nxt     = res_rx_ok_r ? 64'(slot_q & byte_mask(cnt_r)) : '0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    box_r        <= box_nxt;
    key_r        <= key_nxt;
    tx_r         <= tx_nxt;
    cnt_r        <= cnt_nxt;
    scan_idx_r   <= scan_idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    res_status_r <= res_status_nxt;
    res_box_r    <= res_box_nxt;
    res_full_r   <= res_full_nxt;
    res_empty_r  <= res_empty_nxt;
    res_rx_ok_r  <= res_rx_ok_nxt;
    out_status_r <= out_status_nxt;
    out_box_r    <= out_box_nxt;
    out_rx_r     <= out_rx_nxt;
    out_full_r   <= out_full_nxt;
    out_empty_r  <= out_empty_nxt;
  end

endmodule
`default_nettype wire
